// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/htb_pkg.sv =====
// ----------------------------------------------------------------------------
// htb_pkg
// Constants, codes and controller/datapath interface types for the Huffman
// table builder.
// ----------------------------------------------------------------------------
package htb_pkg;

  localparam int MAX_LEAVES = 16;
  localparam int NODE_CNT   = 2 * MAX_LEAVES - 1;
  localparam int LEAF_W     = $clog2(MAX_LEAVES);
  localparam int NODE_W     = $clog2(NODE_CNT);
  localparam int CNT_W      = 5;
  localparam int SYM_W      = 8;
  localparam int WT_W       = 16;
  localparam int SUM_W      = WT_W + LEAF_W;
  localparam int CODE_W     = MAX_LEAVES - 1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_DECODE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_BUILD = 2'd0,
    KIND_BIT   = 2'd1,
    KIND_SYM   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef struct packed {
    logic  load_leaf;
    logic  build_init;
    logic  scan_step;
    logic  merge;
    logic  code_step;
    logic  build_done;
    logic  enc_init;
    logic  enc_step;
    logic  dec_step;
    logic  out_load;
    kind_e out_kind;
  } htb_cmd_t;

  typedef struct packed {
    logic built;
    logic out_free;
    logic enc_hit;
    logic dec_leaf;
    logic scan_last;
    logic merge_last;
    logic code_up;
    logic code_last_leaf;
    logic enc_last;
  } htb_sts_t;

endpackage

// ===== hdl/huffman_table_builder_codec_top.sv =====
// One transaction is in work at a time, and result stalls hold it. A load
// writes its leaf when accepted; an encode sends its code bits as one result
// each; a decode walks one edge per accepted bit and sends a symbol only when
// a leaf is reached; an error is sent as a result. A build scans and merges
// for each new node, walks each leaf's code, then sends its result.
// Reset: tree marked unbuilt, leaf count 2, output empty; tables undefined.
// ----------------------------------------------------------------------------
// huffman_table_builder_codec_top
// Static Huffman code builder with a bit-serial encoder and tree-walk decoder.
// ----------------------------------------------------------------------------
module huffman_table_builder_codec_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input transaction channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [htb_pkg::LEAF_W-1:0]    leaf_index_i,
  input  logic [htb_pkg::SYM_W-1:0]     symbol_i,
  input  logic [htb_pkg::WT_W-1:0]      weight_i,
  input  logic                          code_bit_i,
  // result transaction channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    result_kind_o,
  output logic                          bit_out_o,
  output logic [htb_pkg::SYM_W-1:0]     symbol_out_o,
  output logic                          last_o,
  // leaf-count register
  input  logic                          cfg_we_i,
  input  logic [htb_pkg::CNT_W-1:0]     cfg_data_i
);
  import htb_pkg::*;

  htb_cmd_t cmd;
  htb_sts_t sts;

  // Sequence each transaction; the controller alone decides stalls
  htb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the tables and the output register; the result register parts the
  // two channels so the next result can load as the current one leaves
  htb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .leaf_index_i  (leaf_index_i),
    .symbol_i      (symbol_i),
    .weight_i      (weight_i),
    .code_bit_i    (code_bit_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .bit_out_o     (bit_out_o),
    .symbol_out_o  (symbol_out_o),
    .last_o        (last_o)
  );

endmodule

// ===== hdl/htb_dp.sv =====
// ----------------------------------------------------------------------------
// htb_dp
// Datapath: leaf and node tables, merge scan, code walk, encode and decode
// lookups, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htb_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  htb_pkg::htb_cmd_t             cmd_i,
  output htb_pkg::htb_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [htb_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic [htb_pkg::LEAF_W-1:0]    leaf_index_i,
  input  logic [htb_pkg::SYM_W-1:0]     symbol_i,
  input  logic [htb_pkg::WT_W-1:0]      weight_i,
  input  logic                          code_bit_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [1:0]                    result_kind_o,
  output logic                          bit_out_o,
  output logic [htb_pkg::SYM_W-1:0]     symbol_out_o,
  output logic                          last_o
);
  import htb_pkg::*;

  logic [SYM_W-1:0]  leaf_sym_q  [MAX_LEAVES];
  logic [WT_W-1:0]   leaf_wt_q   [MAX_LEAVES];
  logic [SUM_W-1:0]  node_wt_q   [NODE_CNT];
  logic [NODE_W-1:0] parent_q    [NODE_CNT];
  logic [NODE_W-1:0] left_q      [NODE_CNT];
  logic [NODE_W-1:0] right_q     [NODE_CNT];
  logic [CODE_W-1:0] code_bits_q [MAX_LEAVES];
  logic [LEAF_W-1:0] code_len_q  [MAX_LEAVES];
  logic [NODE_CNT-1:0] pv_q, side_q;

  logic [CNT_W-1:0]  count_q;
  logic              built_q;
  logic [NODE_W-1:0] dec_q;
  logic [LEAF_W-1:0] i_q, l_q, enc_j_q, cnt_q, len_q;
  logic [NODE_W-1:0] j_q, x1_q, x2_q, c_q;
  logic [SUM_W-1:0]  m1_q, m2_q;
  logic [CODE_W-1:0] code_q;
  logic [SYM_W-1:0]  res_sym_q;

  logic              out_valid_q, out_bit_q, out_last_q;
  logic [1:0]        out_kind_q;
  logic [SYM_W-1:0]  out_sym_q;

  logic [NODE_W-1:0] n, root, node_new, dec_node, next_node;
  logic [NODE_W:0]   two_n_m1;
  logic [SUM_W-1:0]  wj;
  logic              enc_hit;
  logic [LEAF_W-1:0] hit_idx;
  logic              out_free, enc_bit, enc_last;

  // Effective leaf count, clamped to the legal range
  always_comb begin
    if (count_q < CNT_W'(2)) begin
      n = NODE_W'(2);
    end else if (int'(count_q) > MAX_LEAVES) begin
      n = NODE_W'(MAX_LEAVES);
    end else begin
      n = NODE_W'(count_q);
    end
  end

  assign two_n_m1 = {n, 1'b0} - (NODE_W+1)'(1);
  assign root     = NODE_W'(two_n_m1 - (NODE_W+1)'(1));
  assign node_new = n + NODE_W'(i_q);

  assign wj = (j_q < n) ? SUM_W'(leaf_wt_q[j_q[LEAF_W-1:0]]) : node_wt_q[j_q];

  // Lowest used leaf holding the symbol
  always_comb begin
    enc_hit = 1'b0;
    hit_idx = '0;
    for (int k = MAX_LEAVES - 1; k >= 0; k--) begin
      if (k < int'(n) && leaf_sym_q[k] == symbol_i) begin
        enc_hit = 1'b1;
        hit_idx = LEAF_W'(k);
      end
    end
  end

  assign dec_node  = ({1'b0, dec_q} >= two_n_m1 || dec_q < n) ? root : dec_q;
  assign next_node = code_bit_i ? right_q[dec_node] : left_q[dec_node];

  assign enc_bit  = code_bits_q[enc_j_q][cnt_q];
  assign enc_last = (cnt_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.built          = built_q;
    sts_o.out_free       = out_free;
    sts_o.enc_hit        = enc_hit;
    sts_o.dec_leaf       = (next_node < n);
    sts_o.scan_last      = (j_q == node_new - NODE_W'(1));
    sts_o.merge_last     = (NODE_W'(i_q) == n - NODE_W'(2));
    sts_o.code_up        = pv_q[c_q];
    sts_o.code_last_leaf = (NODE_W'(l_q) == n - NODE_W'(1));
    sts_o.enc_last       = enc_last;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CNT_W'(2);
      built_q     <= 1'b0;
      dec_q       <= NODE_W'(2);
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
        built_q <= 1'b0;
      end
      if (cmd_i.load_leaf) begin
        built_q <= 1'b0;
      end
      if (cmd_i.build_init) begin
        pv_q <= '0;
      end
      if (cmd_i.merge) begin
        pv_q[x1_q] <= 1'b1;
        pv_q[x2_q] <= 1'b1;
      end
      if (cmd_i.build_done) begin
        built_q <= 1'b1;
        dec_q   <= root;
      end
      if (cmd_i.dec_step) begin
        if (next_node < n || {1'b0, next_node} >= two_n_m1) begin
          dec_q <= root;
        end else begin
          dec_q <= next_node;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tables, work registers and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_leaf) begin
      leaf_sym_q[leaf_index_i] <= symbol_i;
      leaf_wt_q[leaf_index_i]  <= weight_i;
    end
    if (cmd_i.build_init) begin
      i_q  <= '0;
      j_q  <= '0;
      m1_q <= '1;
      m2_q <= '1;
      x1_q <= '0;
      x2_q <= '0;
    end
    if (cmd_i.scan_step) begin
      j_q <= j_q + NODE_W'(1);
      if (!pv_q[j_q]) begin
        if (wj < m1_q) begin
          m2_q <= m1_q;
          x2_q <= x1_q;
          m1_q <= wj;
          x1_q <= j_q;
        end else if (wj < m2_q) begin
          m2_q <= wj;
          x2_q <= j_q;
        end
      end
    end
    if (cmd_i.merge) begin
      parent_q[x1_q]    <= node_new;
      parent_q[x2_q]    <= node_new;
      side_q[x1_q]      <= 1'b0;
      side_q[x2_q]      <= 1'b1;
      node_wt_q[node_new] <= m1_q + m2_q;
      left_q[node_new]  <= x1_q;
      right_q[node_new] <= x2_q;
      i_q  <= i_q + LEAF_W'(1);
      j_q  <= '0;
      m1_q <= '1;
      m2_q <= '1;
      x1_q <= '0;
      x2_q <= '0;
      l_q    <= '0;
      c_q    <= '0;
      len_q  <= '0;
      code_q <= '0;
    end
    if (cmd_i.code_step) begin
      if (pv_q[c_q]) begin
        code_q[len_q] <= side_q[c_q];
        len_q         <= len_q + LEAF_W'(1);
        c_q           <= parent_q[c_q];
      end else begin
        code_bits_q[l_q] <= code_q;
        code_len_q[l_q]  <= len_q;
        l_q    <= l_q + LEAF_W'(1);
        c_q    <= NODE_W'(l_q) + NODE_W'(1);
        len_q  <= '0;
        code_q <= '0;
      end
    end
    if (cmd_i.enc_init) begin
      enc_j_q <= hit_idx;
      cnt_q   <= code_len_q[hit_idx] - LEAF_W'(1);
    end
    if (cmd_i.enc_step) begin
      cnt_q <= cnt_q - LEAF_W'(1);
    end
    if (cmd_i.dec_step) begin
      res_sym_q <= leaf_sym_q[next_node[LEAF_W-1:0]];
    end
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_bit_q  <= (cmd_i.out_kind == KIND_BIT) ? enc_bit : 1'b0;
      out_sym_q  <= (cmd_i.out_kind == KIND_SYM) ? res_sym_q : '0;
      out_last_q <= (cmd_i.out_kind == KIND_BIT) ? enc_last : 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign bit_out_o     = out_bit_q;
  assign symbol_out_o  = out_sym_q;
  assign last_o        = out_last_q;

  `HTB_ASSERT_IMP(a_merge_distinct, cmd_i.merge, x1_q != x2_q, "merge picked one node twice")
  `HTB_ASSERT_IMP(a_code_len, cmd_i.code_step && !pv_q[c_q], NODE_W'(len_q) < n, "code too long")

endmodule

// ===== hdl/htb_ctrl.sv =====
// ----------------------------------------------------------------------------
// htb_ctrl
// Controller: sequences load, build, encode and decode over the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  htb_pkg::htb_sts_t sts_i,
  output htb_pkg::htb_cmd_t cmd_o
);
  import htb_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_MERGE = 7'b0000100,
    ST_CODE  = 7'b0001000,
    ST_BDONE = 7'b0010000,
    ST_ENC   = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.out_kind = KIND_BUILD;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_e'(opcode_i))
            OP_LOAD: begin
              cmd_o.load_leaf = 1'b1;
            end
            OP_BUILD: begin
              cmd_o.build_init = 1'b1;
              state_d = ST_SCAN;
            end
            OP_ENCODE: begin
              if (sts_i.built && sts_i.enc_hit) begin
                cmd_o.enc_init = 1'b1;
                state_d = ST_ENC;
              end else begin
                kind_d  = KIND_ERR;
                state_d = ST_RESP;
              end
            end
            OP_DECODE: begin
              if (!sts_i.built) begin
                kind_d  = KIND_ERR;
                state_d = ST_RESP;
              end else begin
                cmd_o.dec_step = 1'b1;
                if (sts_i.dec_leaf) begin
                  kind_d  = KIND_SYM;
                  state_d = ST_RESP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d = sts_i.merge_last ? ST_CODE : ST_SCAN;
      end
      ST_CODE: begin
        cmd_o.code_step = 1'b1;
        if (!sts_i.code_up && sts_i.code_last_leaf) state_d = ST_BDONE;
      end
      ST_BDONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = KIND_BUILD;
          cmd_o.build_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ENC: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_BIT;
          cmd_o.enc_step = 1'b1;
          if (sts_i.enc_last) state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = kind_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_ERR;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  `HTB_ASSERT_IMP(a_load_free, cmd_o.out_load, sts_i.out_free, "output overwritten")
  `HTB_ASSERT_NXT(a_built_set, cmd_o.build_done, sts_i.built, "tree not marked built")

endmodule
